@@ src/assert_macros.svh @@
// assertion macros for the vector normalizer
// expects clk_i and rst_ni in the scope of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define VN_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("vector3_normalize assertion failed");
`define VN_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("vector3_normalize forbidden condition seen");
`else
`define VN_ASSERT(lbl, prop)
`define VN_NEVER(lbl, cond)
`endif
`endif

@@ src/vn_pkg.sv @@
// shared widths, constants and stage records for the vector normalizer
// no dependencies
package vn_pkg;

  localparam int unsigned COMP_W     = 32;
  localparam int unsigned OUT_W      = 32;
  localparam int unsigned OUT_FRAC   = 30;
  localparam int unsigned TOL_W      = 31;
  localparam int unsigned SUM_W      = 2 * COMP_W + 2;
  localparam int unsigned RAD_W      = 128;
  localparam int unsigned ROOT_W     = RAD_W / 2;
  localparam int unsigned SREM_W     = ROOT_W + 3;
  localparam int unsigned K_W        = $clog2(ROOT_W);
  localparam int unsigned NORM_STEPS = $clog2(RAD_W) - 1;
  localparam int unsigned DREM_W     = ROOT_W + 1;
  localparam int unsigned QUO_W      = OUT_FRAC + 1;
  localparam int unsigned DIV_STEPS  = QUO_W;

  localparam logic [TOL_W-1:0]        TOL_RESET = TOL_W'(66);
  localparam logic [OUT_W-1:0]        UNIT_ONE  = OUT_W'(1) << OUT_FRAC;
  localparam logic signed [OUT_W-1:0] UNIT_POS  = $signed(UNIT_ONE);
  localparam logic signed [OUT_W-1:0] UNIT_NEG  = -$signed(UNIT_ONE);

  typedef struct packed {
    logic                   too;
    logic [2:0]             neg;
    logic [2:0][COMP_W-1:0] mag;
  } vn_side_t;

  typedef struct packed {
    vn_side_t            side;
    logic [K_W-1:0]      k;
    logic [RAD_W-1:0]    rad;
    logic [ROOT_W-1:0]   root;
    logic [SREM_W-1:0]   rem;
  } vn_sq_t;

  typedef struct packed {
    vn_side_t               side;
    logic [ROOT_W-1:0]      root;
    logic [2:0][DREM_W-1:0] rem;
    logic [2:0][QUO_W-1:0]  quo;
  } vn_dv_t;

endpackage

@@ src/vn_channels.sv @@
// input and output channel interfaces of the vector normalizer
// depends on vn_pkg
interface vn_in_if;
  import vn_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [COMP_W-1:0] comp_x;
  logic signed [COMP_W-1:0] comp_y;
  logic signed [COMP_W-1:0] comp_z;
  modport source (output valid, comp_x, comp_y, comp_z, input ready);
  modport sink (input valid, comp_x, comp_y, comp_z, output ready);
endinterface

interface vn_out_if;
  import vn_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] unit_x;
  logic signed [OUT_W-1:0] unit_y;
  logic signed [OUT_W-1:0] unit_z;
  logic                    too_close;
  modport source (output valid, unit_x, unit_y, unit_z, too_close, input ready);
  modport sink (input valid, unit_x, unit_y, unit_z, too_close, output ready);
endinterface

@@ src/vn_sqrt_cell.sv @@
// one root bit of the pipelined integer square root
// depends on vn_pkg
module vn_sqrt_cell (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  vn_pkg::vn_sq_t data_i,
  output logic           valid_o,
  output vn_pkg::vn_sq_t data_o
);
  import vn_pkg::*;

  logic [SREM_W-1:0] rem_sh;
  logic [SREM_W-1:0] trial;
  vn_sq_t            data_d;
  vn_sq_t            data_q;
  logic              valid_q;

  always_comb begin
    data_d = data_i;
    // bring down the next two radicand bits
    rem_sh = {data_i.rem[SREM_W-3:0], data_i.rad[RAD_W-1 -: 2]};
    trial  = SREM_W'({data_i.root, 2'b01});
    data_d.rad = data_i.rad << 2;
    if (rem_sh >= trial) begin
      data_d.rem  = rem_sh - trial;
      data_d.root = {data_i.root[ROOT_W-2:0], 1'b1};
    end else begin
      data_d.rem  = rem_sh;
      data_d.root = {data_i.root[ROOT_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;
endmodule

@@ src/vn_div_cell.sv @@
// one quotient bit for all three lanes of the restoring divider
// depends on vn_pkg
module vn_div_cell (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  vn_pkg::vn_dv_t data_i,
  output logic           valid_o,
  output vn_pkg::vn_dv_t data_o
);
  import vn_pkg::*;

  vn_dv_t            data_d;
  vn_dv_t            data_q;
  logic              valid_q;
  logic [2:0]        qbit;
  logic [2:0][DREM_W-1:0] diff;

  always_comb begin
    data_d = data_i;
    for (int l = 0; l < 3; l++) begin
      qbit[l] = data_i.rem[l] >= {1'b0, data_i.root};
      diff[l] = qbit[l] ? (data_i.rem[l] - {1'b0, data_i.root}) : data_i.rem[l];
      // remainder leaves the cell already doubled
      data_d.rem[l] = {diff[l][DREM_W-2:0], 1'b0};
      data_d.quo[l] = {data_i.quo[l][QUO_W-2:0], qbit[l]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;
endmodule

@@ src/vector3_normalize_top.sv @@
// one vector per cycle sustained while the output is not stalled
// stages: magnitude, squares, sum, 6 normalize shifts, 64 square root cells
// (one root bit each), operand shift, 31 divider cells, round and saturate
// the whole row advances together; it holds when the output register is full and stalled
// reset clears all valid bits and loads tolerance with 66; no clearing pass
module vector3_normalize_top (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    tol_we_i,
  input  logic [vn_pkg::TOL_W-1:0] tol_wdata_i,
  vn_in_if.sink                   in_i,
  vn_out_if.source                out_o
);
  import vn_pkg::*;
  `include "assert_macros.svh"

  logic               adv;
  logic [TOL_W-1:0]   tol_q;

  logic [2:0][COMP_W-1:0] comp_in;
  vn_side_t           side_d;
  vn_side_t           side1_q;
  vn_side_t           side2_q;
  logic               v1_q;
  logic               v2_q;
  logic [2:0][2*COMP_W-1:0] sqr_q;
  logic [SUM_W-1:0]   sum;

  vn_sq_t             nrm_q [NORM_STEPS+1];
  logic               nv_q  [NORM_STEPS+1];
  vn_sq_t             sq_d  [ROOT_W+1];
  logic               sv    [ROOT_W+1];
  vn_dv_t             dv0_d;
  vn_dv_t             dv_d  [DIV_STEPS+1];
  logic               dvv   [DIV_STEPS+1];
  logic               dv0_valid_q;
  vn_dv_t             dv0_q;

  logic [2:0][OUT_W-1:0] res_d;
  logic [2:0][OUT_W-1:0] res_q;
  logic [2:0][OUT_W-1:0] qr;
  logic               too_q;
  logic               out_valid_q;

  assign adv        = !out_valid_q || out_o.ready;
  assign in_i.ready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= TOL_RESET;
    end else if (tol_we_i) begin
      tol_q <= tol_wdata_i;
    end
  end

  // magnitudes and tolerance test
  assign comp_in = {in_i.comp_z, in_i.comp_y, in_i.comp_x};
  always_comb begin
    side_d.too = 1'b1;
    for (int l = 0; l < 3; l++) begin
      side_d.neg[l] = comp_in[l][COMP_W-1];
      // most negative value wraps to its exact unsigned magnitude
      side_d.mag[l] = side_d.neg[l] ? (~comp_in[l] + COMP_W'(1)) : comp_in[l];
      if (side_d.mag[l] >= COMP_W'(tol_q)) begin
        side_d.too = 1'b0;
      end
    end
  end

  assign sum = SUM_W'(sqr_q[0]) + SUM_W'(sqr_q[1]) + SUM_W'(sqr_q[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q     <= 1'b0;
      v2_q     <= 1'b0;
      nv_q[0]  <= 1'b0;
    end else if (adv) begin
      v1_q     <= in_i.valid;
      v2_q     <= v1_q;
      nv_q[0]  <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      side1_q <= side_d;
      side2_q <= side1_q;
      for (int l = 0; l < 3; l++) begin
        sqr_q[l] <= (2*COMP_W)'(side1_q.mag[l]) * (2*COMP_W)'(side1_q.mag[l]);
      end
      nrm_q[0].side     <= '{too: side2_q.too || (sum == '0), neg: side2_q.neg,
                             mag: side2_q.mag};
      nrm_q[0].k        <= '0;
      nrm_q[0].rad      <= RAD_W'(sum);
      nrm_q[0].root     <= '0;
      nrm_q[0].rem      <= '0;
    end
  end

  // even left shifts until one of the top two bits is set
  for (genvar j = 0; j < NORM_STEPS; j++) begin : g_norm
    localparam int unsigned AMT = RAD_W >> (j + 1);
    vn_sq_t nrm_d;
    always_comb begin
      nrm_d = nrm_q[j];
      if (nrm_q[j].rad[RAD_W-1 -: AMT] == '0) begin
        nrm_d.rad = nrm_q[j].rad << AMT;
        nrm_d.k   = nrm_q[j].k + K_W'(AMT / 2);
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        nv_q[j+1] <= 1'b0;
      end else if (adv) begin
        nv_q[j+1] <= nv_q[j];
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        nrm_q[j+1] <= nrm_d;
      end
    end
  end

  assign sq_d[0] = nrm_q[NORM_STEPS];
  assign sv[0]   = nv_q[NORM_STEPS];

  for (genvar i = 0; i < ROOT_W; i++) begin : g_sqrt
    vn_sqrt_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (adv),
      .valid_i (sv[i]),
      .data_i  (sq_d[i]),
      .valid_o (sv[i+1]),
      .data_o  (sq_d[i+1])
    );
  end

  // dividend starts as |c| << k, never above the root
  always_comb begin
    dv0_d.side = sq_d[ROOT_W].side;
    dv0_d.root = sq_d[ROOT_W].root;
    for (int l = 0; l < 3; l++) begin
      dv0_d.rem[l] = DREM_W'(sq_d[ROOT_W].side.mag[l]) << sq_d[ROOT_W].k;
      dv0_d.quo[l] = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv0_valid_q <= 1'b0;
    end else if (adv) begin
      dv0_valid_q <= sv[ROOT_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dv0_q <= dv0_d;
    end
  end

  assign dv_d[0] = dv0_q;
  assign dvv[0]  = dv0_valid_q;

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
    vn_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (adv),
      .valid_i (dvv[i]),
      .data_i  (dv_d[i]),
      .valid_o (dvv[i+1]),
      .data_o  (dv_d[i+1])
    );
  end

  // round half up, saturate, apply sign; fallback when too close
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      qr[l] = OUT_W'(dv_d[DIV_STEPS].quo[l]) +
              OUT_W'(dv_d[DIV_STEPS].rem[l] >= {1'b0, dv_d[DIV_STEPS].root});
      if (qr[l] > UNIT_ONE) begin
        qr[l] = UNIT_ONE;
      end
      res_d[l] = dv_d[DIV_STEPS].side.neg[l] ? (~qr[l] + OUT_W'(1)) : qr[l];
    end
    if (dv_d[DIV_STEPS].side.too) begin
      res_d[0] = UNIT_ONE;
      res_d[1] = '0;
      res_d[2] = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= dvv[DIV_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q <= res_d;
      too_q <= dv_d[DIV_STEPS].side.too;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.unit_x    = $signed(res_q[0]);
  assign out_o.unit_y    = $signed(res_q[1]);
  assign out_o.unit_z    = $signed(res_q[2]);
  assign out_o.too_close = too_q;

  `VN_ASSERT(a_fallback_shape, out_o.valid && out_o.too_close |-> out_o.unit_x == UNIT_POS && out_o.unit_y == 0 && out_o.unit_z == 0)
  `VN_ASSERT(a_unit_range, out_o.valid |-> out_o.unit_x <= UNIT_POS && out_o.unit_x >= UNIT_NEG && out_o.unit_y <= UNIT_POS && out_o.unit_y >= UNIT_NEG && out_o.unit_z <= UNIT_POS && out_o.unit_z >= UNIT_NEG)
  `VN_NEVER(a_norm_done, sv[0] && !sq_d[0].side.too && sq_d[0].rad[RAD_W-1 -: 2] == 2'b00)
endmodule

@@ verif/vector3_normalize_top_tb.sv @@
// self-checking testbench for vector3_normalize_top: random and directed vectors,
// tolerance sweeps, handshake idling; depends on vn_pkg, vn_channels and the rtl top
module vector3_normalize_top_tb;
  import vn_pkg::*;

  typedef struct {
    logic signed [COMP_W-1:0] x;
    logic signed [COMP_W-1:0] y;
    logic signed [COMP_W-1:0] z;
  } vec_t;

  typedef struct {
    logic signed [OUT_W-1:0] ux;
    logic signed [OUT_W-1:0] uy;
    logic signed [OUT_W-1:0] uz;
    logic                    too;
  } unit_t;

  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam int unsigned DRAIN_CYCLES   = 150;

  logic clk_i;
  logic rst_ni;
  logic tol_we;
  logic [TOL_W-1:0] tol_wdata;

  vn_in_if  in_ch ();
  vn_out_if out_ch ();

  vector3_normalize_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tol_we_i    (tol_we),
    .tol_wdata_i (tol_wdata),
    .in_i        (in_ch),
    .out_o       (out_ch)
  );

  vec_t        pending_vecs[$];
  unit_t       expected_units[$];
  logic [TOL_W-1:0] tol_shadow;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned n_errors;
  int unsigned n_sent;
  int unsigned n_checked;
  int unsigned n_too_close;
  int unsigned quiet_cycles;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // integer square root of a 128-bit radicand, one root bit at a time
  function automatic logic [63:0] root_of(input logic [127:0] rad);
    logic [63:0]  acc;
    logic [63:0]  cand;
    logic [127:0] sq;
    acc = '0;
    for (int i = 63; i >= 0; i--) begin
      cand = acc | (64'd1 << i);
      sq = 128'(cand) * 128'(cand);
      if (sq <= rad) acc = cand;
    end
    return acc;
  endfunction

  function automatic unit_t normalize(input vec_t v, input logic [TOL_W-1:0] tol);
    logic [COMP_W-1:0] comp [3];
    logic [63:0]  mag [3];
    logic         neg [3];
    logic [127:0] sum;
    logic [127:0] num;
    logic [127:0] quo;
    logic [127:0] rem;
    logic [63:0]  r;
    logic [OUT_W-1:0] res [3];
    int unsigned  top;
    int unsigned  k;
    logic         too;
    unit_t        u;
    comp[0] = v.x; comp[1] = v.y; comp[2] = v.z;
    sum = '0;
    too = 1'b1;
    for (int i = 0; i < 3; i++) begin
      neg[i] = comp[i][COMP_W-1];
      // most negative value keeps its full magnitude
      mag[i] = neg[i] ? (64'd1 << COMP_W) - 64'(comp[i]) : 64'(comp[i]);
      if (mag[i] >= 64'(tol)) too = 1'b0;
      sum += 128'(mag[i]) * 128'(mag[i]);
    end
    if (too || sum == '0) begin
      u.ux = UNIT_POS; u.uy = '0; u.uz = '0; u.too = 1'b1;
      return u;
    end
    top = 0;
    for (int i = 0; i < 128; i++) if (sum[i]) top = i;
    k = (127 - top) / 2;
    r = root_of(sum << (2 * k));
    for (int i = 0; i < 3; i++) begin
      num = 128'(mag[i]) << (OUT_FRAC + k);
      quo = num / 128'(r);
      rem = num % 128'(r);
      if ((rem << 1) >= 128'(r)) quo += 1;
      if (quo > (128'd1 << OUT_FRAC)) quo = 128'd1 << OUT_FRAC;
      res[i] = neg[i] ? OUT_W'(-quo) : OUT_W'(quo);
    end
    u.ux = res[0]; u.uy = res[1]; u.uz = res[2]; u.too = 1'b0;
    return u;
  endfunction

  // wide spread of magnitudes so small, mid and full-scale vectors all show up
  function automatic logic signed [COMP_W-1:0] rand_comp();
    logic [COMP_W-1:0] c;
    case ($urandom_range(0, 9))
      0: c = 32'h7FFF_FFFF;
      1: c = 32'h8000_0000;
      2: c = COMP_W'($urandom_range(0, 200)) ^ {COMP_W{$urandom_range(0, 1) == 1}};
      3: c = '0;
      default: c = $urandom() >>> $urandom_range(0, 31);
    endcase
    return $signed(c);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ch.valid  <= 1'b0;
      in_ch.comp_x <= '0;
      in_ch.comp_y <= '0;
      in_ch.comp_z <= '0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (pending_vecs.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        vec_t v;
        v = pending_vecs.pop_front();
        in_ch.valid  <= 1'b1;
        in_ch.comp_x <= v.x;
        in_ch.comp_y <= v.y;
        in_ch.comp_z <= v.z;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      vec_t  v;
      unit_t want;
      if (tol_we) tol_shadow = tol_wdata;
      if (in_ch.valid && in_ch.ready) begin
        v.x = in_ch.comp_x; v.y = in_ch.comp_y; v.z = in_ch.comp_z;
        expected_units.push_back(normalize(v, tol_shadow));
        n_sent++;
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_units.size() == 0) begin
          $display("%0t: unexpected result %h %h %h too_close=%b", $time,
                   out_ch.unit_x, out_ch.unit_y, out_ch.unit_z, out_ch.too_close);
          n_errors++;
        end else begin
          want = expected_units.pop_front();
          if (want.ux !== out_ch.unit_x || want.uy !== out_ch.unit_y ||
              want.uz !== out_ch.unit_z || want.too !== out_ch.too_close) begin
            $display("%0t: expected %h %h %h too_close=%b, got %h %h %h too_close=%b",
                     $time, want.ux, want.uy, want.uz, want.too,
                     out_ch.unit_x, out_ch.unit_y, out_ch.unit_z, out_ch.too_close);
            n_errors++;
          end
          if (want.too) n_too_close++;
          n_checked++;
        end
      end
      // watchdog on cycles with no transfer at either side
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
          $display("%0t: watchdog expired with %0d results outstanding", $time,
                   expected_units.size());
          $display("SCOREBOARD MISMATCH");
          $finish;
        end
      end
    end
  end

  task automatic add_vec(input logic [COMP_W-1:0] x, input logic [COMP_W-1:0] y,
                         input logic [COMP_W-1:0] z);
    vec_t v;
    v.x = $signed(x); v.y = $signed(y); v.z = $signed(z);
    pending_vecs.push_back(v);
  endtask

  task automatic run_random(input int unsigned count, input int unsigned idle,
                            input int unsigned stall);
    send_idle_pct  = idle;
    recv_stall_pct = stall;
    for (int i = 0; i < count; i++) add_vec(rand_comp(), rand_comp(), rand_comp());
  endtask

  task automatic settle_and_write(input logic [TOL_W-1:0] value);
    wait (pending_vecs.size() == 0 && expected_units.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    tol_we    <= 1'b1;
    tol_wdata <= value;
    @(posedge clk_i);
    tol_we    <= 1'b0;
  endtask

  initial begin
    rst_ni = 1'b0;
    tol_we = 1'b0;
    tol_wdata = '0;
    tol_shadow = TOL_RESET;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    n_errors = 0; n_sent = 0; n_checked = 0; n_too_close = 0; quiet_cycles = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: extremes, tolerance edges, lone axes
    add_vec(0, 0, 0);
    add_vec(65, -65, 0);
    add_vec(66, 0, 0);
    add_vec(0, -66, 0);
    add_vec(0, 0, 32'h7FFF_FFFF);
    add_vec(32'h8000_0000, 0, 0);
    add_vec(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    add_vec(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    add_vec(32'h7FFF_FFFF, 32'h8000_0000, 1);
    add_vec(1000, 1000, 1000);
    add_vec(-3000, 4000, 0);
    add_vec(32'h0001_0000, 0, 32'hFFFF_0000);
    add_vec(32'hFFFF_FFFF, 0, 32'h4000_0000);
    add_vec(32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_0F0F);
    run_random(150, 0, 0);

    settle_and_write('0);
    add_vec(0, 0, 0);
    add_vec(1, 0, 0);
    add_vec(0, 0, -1);
    run_random(150, 79, 0);

    settle_and_write({TOL_W{1'b1}});
    add_vec(32'h7FFF_FFFE, 32'h8000_0001, 0);
    add_vec(32'h7FFF_FFFF, 0, 0);
    run_random(150, 0, 79);

    settle_and_write(TOL_W'($urandom_range(0, 2000)));
    run_random(150, 25, 25);

    wait (pending_vecs.size() == 0 && expected_units.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("covered %0d vectors, %0d results checked, %0d fallback results",
             n_sent, n_checked, n_too_close);
    $display("tolerance swept over reset, zero, full scale and a random value");
    if (n_errors == 0 && expected_units.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+src
src/vn_pkg.sv
src/vn_channels.sv
src/vn_sqrt_cell.sv
src/vn_div_cell.sv
src/vector3_normalize_top.sv
verif/vector3_normalize_top_tb.sv
